// ===== design/ssm_pkg.sv =====
// Shared types, constants and helpers of the substring search matcher.
// No dependencies; compiled first.
package ssm_pkg;

   localparam int MAX_PATTERN_DEF = 120;
   localparam int MAX_LINE_DEF    = 65536;

   localparam int CHAR_W     = 8;
   localparam int PAT_IDX_W  = 7;
   localparam int LEN_W      = 7;
   localparam int COL_OUT_W  = 16;
   localparam int CELL_IDX_W = PAT_IDX_W + 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   typedef logic [CHAR_W-1:0]    char_type;
   typedef logic [LEN_W-1:0]     len_type;
   typedef logic [COL_OUT_W-1:0] col_out_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TEXT = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 1'b0,
      CSR_CASE_SENSITIVE = 1'b1
   } csr_idx_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic                 load;
      logic                 step;
      logic                 restart;
      logic                 clear;
      logic                 fold_en;
      logic [PAT_IDX_W-1:0] index;
      char_type             data;
   } cell_ctl_type;

   typedef struct packed {
      logic step;
      logic restart;
   } col_ctl_type;

   typedef struct packed {
      logic        match_found;
      col_out_type match_column;
      col_out_type text_column;
   } rsp_type;

   // Map ASCII upper case to lower case when folding is on.
   function automatic char_type fold_char(input char_type c, input logic fold_en);
      char_type r;
      r = c;
      if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== design/ssm_ifs.sv =====
// Valid/ready channel interfaces of the substring search matcher.
// Depends on ssm_pkg for field widths.
interface ssm_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   ssm_pkg::char_type             character;
   logic [ssm_pkg::PAT_IDX_W-1:0] pattern_index;
   logic                          line_start;

   modport source (output valid, operation, character, pattern_index, line_start,
                   input ready);
   modport sink   (input valid, operation, character, pattern_index, line_start,
                   output ready);
endinterface

interface ssm_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 match_found;
   ssm_pkg::col_out_type match_column;
   ssm_pkg::col_out_type text_column;

   modport source (output valid, match_found, match_column, text_column, input ready);
   modport sink   (input valid, match_found, match_column, text_column, output ready);
endinterface

// ===== design/substring_search_matcher_unit.sv =====
// Channel    | Dir | Word
// req_bus    | in  | operation, character, pattern_index, line_start
// rsp_bus    | out | match_found, match_column, text_column (one per text byte)
// csr_*      | in  | write enable, index 0 pattern_length, 1 case_sensitive
//
// One word per cycle while req_bus.ready is high: every cell of the shift-and
// chain compares its pattern byte with the text byte and passes its partial
// match bit to the next cell. Each result is registered in the output register
// or in the skid word behind a stalled result. Pattern loads give no result.
// req_bus.ready drops only while the skid word is full behind a stalled result.
// Reset is synchronous; pattern bytes are not cleared and must be loaded before use.
module substring_search_matcher_unit #(
   parameter int MAX_PATTERN = ssm_pkg::MAX_PATTERN_DEF,
   parameter int MAX_LINE    = ssm_pkg::MAX_LINE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ssm_req_if.sink                        req_bus,
   ssm_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [ssm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ssm_pkg::*;

   localparam int SEL_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   len_type      len_ff, len_in;
   logic         cs_ff, cs_in;
   logic         len_written;
   logic         req_ready;
   logic         accept;
   logic         is_text;
   logic         len_ok;
   logic [7:0]   len_m1;
   logic         found;
   cell_ctl_type cell_ctl;
   col_ctl_type  col_ctl;
   rsp_type      rsp_word;
   logic [MAX_PATTERN-1:0] hits_ff;
   logic [MAX_PATTERN-1:0] hits_next;

   // configuration registers
   always_comb begin
      len_in      = len_ff;
      cs_in       = cs_ff;
      len_written = 1'b0;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_PATTERN_LENGTH: begin
               len_in      = csr_wdata[LEN_W-1:0];
               len_written = 1'b1;
            end
            CSR_CASE_SENSITIVE: begin
               cs_in = csr_wdata[0];
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
         cs_ff  <= 1'b0;
      end else begin
         len_ff <= len_in;
         cs_ff  <= cs_in;
      end
   end

   assign req_bus.ready = req_ready;
   assign accept        = req_bus.valid && req_ready;
   assign is_text       = op_type'(req_bus.operation) == OP_TEXT;

   always_comb begin
      cell_ctl.load    = accept && !is_text;
      cell_ctl.step    = accept && is_text;
      cell_ctl.restart = req_bus.line_start;
      cell_ctl.clear   = (accept && !is_text) || len_written;
      cell_ctl.fold_en = !cs_ff;
      cell_ctl.index   = req_bus.pattern_index;
      cell_ctl.data    = is_text ? fold_char(req_bus.character, !cs_ff)
                                 : req_bus.character;
      col_ctl.step     = accept && is_text;
      col_ctl.restart  = req_bus.line_start;
   end

   for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
      logic prev_hit;
      if (g == 0) begin : g_head
         assign prev_hit = 1'b1;
      end else begin : g_link
         assign prev_hit = hits_ff[g-1];
      end
      ssm_cell #(.CELL_IDX(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .prev_hit (prev_hit),
         .hit_next (hits_next[g]),
         .hit_ff   (hits_ff[g])
      );
   end

   // tap the chain at the last pattern position in use
   always_comb begin
      len_ok = (len_ff != '0) && (int'(len_ff) <= MAX_PATTERN);
      len_m1 = 8'(len_ff) - 8'd1;
      found  = cell_ctl.step && len_ok && hits_next[len_m1[SEL_W-1:0]];
   end

   ssm_col_track #(.MAX_LINE(MAX_LINE)) u_col (
      .clock        (clock),
      .reset        (reset),
      .ctl          (col_ctl),
      .len          (len_ff),
      .found        (found),
      .text_column  (rsp_word.text_column),
      .match_column (rsp_word.match_column)
   );

   assign rsp_word.match_found = found;

   ssm_rsp_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cell_ctl.step),
      .in_data  (rsp_word),
      .in_ready (req_ready),
      .rsp_bus  (rsp_bus)
   );

   // a full skid word always sits behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("skid word held with empty output register");

   a_text_gives_word: assert property (@(posedge clock) disable iff (reset)
      (accept && is_text && !rsp_bus.valid) |=> rsp_bus.valid)
      else $error("text byte accepted but no result word");

   a_load_no_word: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_text && !rsp_bus.valid) |=> !rsp_bus.valid)
      else $error("pattern load produced a result word");

   a_line_start_col: assert property (@(posedge clock) disable iff (reset)
      (accept && is_text && req_bus.line_start && !rsp_bus.valid)
      |=> (rsp_bus.text_column == '0))
      else $error("line start did not restart the column");

   a_match_before_text: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.match_found)
      |-> (rsp_bus.match_column <= rsp_bus.text_column))
      else $error("match starts after the current byte");

endmodule

// ===== design/ssm_cell.sv =====
// One shift-and cell: a pattern byte and the partial match bit of its position.
// Depends on ssm_pkg.
module ssm_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ssm_pkg::cell_ctl_type ctl,
   input  logic                  prev_hit,
   output logic                  hit_next,
   output logic                  hit_ff
);
   import ssm_pkg::*;

   char_type pat_ff, pat_in;
   logic     hit_in;
   logic     load_hit;
   logic     chain_in;
   logic     eq;

   always_comb begin
      load_hit = ctl.load && ({1'b0, ctl.index} == CELL_IDX_W'(CELL_IDX));
      pat_in   = load_hit ? ctl.data : pat_ff;
      eq       = fold_char(pat_ff, ctl.fold_en) == ctl.data;
      // the head cell always starts a fresh prefix; others drop it on a new line
      chain_in = prev_hit & ((CELL_IDX == 0) | ~ctl.restart);
      hit_next = chain_in & eq;
      if (ctl.clear) begin
         hit_in = 1'b0;
      end else if (ctl.step) begin
         hit_in = hit_next;
      end else begin
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

endmodule

// ===== design/ssm_col_track.sv =====
// Column counter per line and start column of a finished match.
// Depends on ssm_pkg.
module ssm_col_track #(
   parameter int MAX_LINE = ssm_pkg::MAX_LINE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ssm_pkg::col_ctl_type ctl,
   input  ssm_pkg::len_type     len,
   input  logic                 found,
   output ssm_pkg::col_out_type text_column,
   output ssm_pkg::col_out_type match_column
);
   import ssm_pkg::*;

   localparam int CW      = $clog2(MAX_LINE);
   localparam int COL_MAX = MAX_LINE - 1;

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] col_cur;
   logic [CW-1:0] start_col;
   logic          saturated;

   function automatic col_out_type cap16(input logic [CW-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
   endfunction

   always_comb begin
      col_cur   = ctl.restart ? '0 : col_ff;
      saturated = col_cur >= CW'(COL_MAX);
      if (ctl.step) begin
         col_in = saturated ? col_cur : col_cur + CW'(1);
      end else begin
         col_in = col_ff;
      end
      start_col   = col_cur - (CW'(len) - CW'(1));
      text_column = cap16(col_cur);
      if (!found) begin
         match_column = '0;
      end else if (saturated) begin
         match_column = 16'hFFFF;
      end else begin
         match_column = cap16(start_col);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

endmodule

// ===== design/ssm_rsp_skid.sv =====
// Output register with a skid word in front of the result channel.
// Depends on ssm_pkg and ssm_rsp_if.
module ssm_rsp_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ssm_pkg::rsp_type in_data,
   output logic             in_ready,
   ssm_rsp_if.source        rsp_bus
);
   import ssm_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   always_comb begin
      out_free      = !out_valid_ff || rsp_bus.ready;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // drain the skid word; no new word can arrive while it is full
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign in_ready             = !skid_valid_ff;
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.match_found  = out_data_ff.match_found;
   assign rsp_bus.match_column = out_data_ff.match_column;
   assign rsp_bus.text_column  = out_data_ff.text_column;

endmodule
